[rtl/rra_pkg.sv]
// rra_pkg: shared types and constants for the rotor-router aggregation block
// holds grid geometry, transaction structs, rotor direction codes and helpers
// no dependencies
package rra_pkg;

  // grid geometry
  localparam int GRID_SIDE = 256;
  localparam int COORD_W   = $clog2(GRID_SIDE);
  localparam int CELL_W    = 2 * COORD_W;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [CELL_W-1:0]  cell_t;

  localparam coord_t CENTER    = coord_t'(GRID_SIDE / 2);
  localparam coord_t COORD_MAX = coord_t'(GRID_SIDE - 1);

  // operation codes
  typedef enum logic {
    OP_DROP  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  // rotor directions, advanced cyclically
  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_UP    = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_t;

  // input transaction
  typedef struct packed {
    op_t        op;
    logic [7:0] cell_row;
    logic [7:0] cell_col;
    logic [1:0] rotor_value;
  } rra_item_t;

  // result transaction
  typedef struct packed {
    logic [7:0] rest_row;
    logic [7:0] rest_col;
    logic       hit_border;
  } rra_result_t;

  // byte coordinate lies inside the grid
  function automatic logic byte_in_grid(logic [7:0] b);
    logic [15:0] w;
    w = {8'b0, b};
    return w < 16'(GRID_SIDE);
  endfunction

  // byte coordinate to grid coordinate
  function automatic coord_t byte_to_coord(logic [7:0] b);
    logic [15:0] w;
    w = {8'b0, b};
    return w[COORD_W-1:0];
  endfunction

  // grid coordinate to reported byte (low 8 bits)
  function automatic logic [7:0] coord_to_byte(coord_t c);
    logic [15:0] w;
    w = 16'(c);
    return w[7:0];
  endfunction

  // cell address from row and column
  function automatic cell_t cell_addr(coord_t r, coord_t c);
    return {r, c};
  endfunction

endpackage

[rtl/rotor_router_aggregation.sv]
// Operation: a rotor write transaction is accepted and gives no result.
// A drop visits cells one at a time, each in a memory read state and then an
// evaluate/update state, until the result is valid; one item at a time.
// The step rate is set by the registered read of the rotor/occupancy memories.
// Reset: synchronous; after reset a clearing pass zeroes the occupancy memory,
// one cell a cycle over all GRID_SIDE*GRID_SIDE (65536) cells, with item_ready low.
module rotor_router_aggregation (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  rra_pkg::rra_item_t  item,
  output logic                result_valid,
  input  logic                result_ready,
  output rra_pkg::rra_result_t result
);
  import rra_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_EVAL  = 4'b1000
  } state_t;

  state_t state, state_next;

  // cell memories
  dir_t rotor_mem [2**CELL_W];
  logic occ_mem   [2**CELL_W];

  cell_t  clr_cnt;
  coord_t pos_row, pos_col;
  dir_t   rot_rd;
  logic   occ_rd;

  logic   rot_we, occ_we, occ_wdata;
  cell_t  rot_waddr, occ_waddr;
  dir_t   rot_wdata;

  logic   item_acc, walk_on, on_border;
  coord_t row_step, col_step;

  assign item_ready = (state == ST_IDLE) && !result_valid;
  assign item_acc   = item_valid && item_ready;

  // border test and walk continuation
  assign on_border = (pos_row == '0) || (pos_col == '0) ||
                     (pos_row == COORD_MAX) || (pos_col == COORD_MAX);
  assign walk_on   = occ_rd && !on_border;

  // one move in the old rotor direction
  always_comb begin
    row_step = pos_row;
    col_step = pos_col;
    unique case (rot_rd)
      DIR_RIGHT: col_step = pos_col + coord_t'(1);
      DIR_UP:    row_step = pos_row - coord_t'(1);
      DIR_LEFT:  col_step = pos_col - coord_t'(1);
      DIR_DOWN:  row_step = pos_row + coord_t'(1);
      default:   row_step = pos_row;
    endcase
  end

  // memory write port selection
  always_comb begin
    rot_we    = 1'b0;
    rot_waddr = cell_addr(pos_row, pos_col);
    rot_wdata = dir_t'(rot_rd + 2'd1);
    occ_we    = 1'b0;
    occ_waddr = cell_addr(pos_row, pos_col);
    occ_wdata = 1'b1;
    if (state == ST_CLEAR) begin
      occ_we    = 1'b1;
      occ_waddr = clr_cnt;
      occ_wdata = 1'b0;
    end else if (state == ST_EVAL) begin
      rot_we = walk_on;
      occ_we = !walk_on;
    end else if (item_acc && item.op == OP_WRITE) begin
      rot_we    = byte_in_grid(item.cell_row) && byte_in_grid(item.cell_col);
      rot_waddr = cell_addr(byte_to_coord(item.cell_row), byte_to_coord(item.cell_col));
      rot_wdata = dir_t'(item.rotor_value);
    end
  end

  // memory ports, registered read
  always_ff @(posedge clk) begin
    if (rot_we) begin
      rotor_mem[rot_waddr] <= rot_wdata;
    end
    if (occ_we) begin
      occ_mem[occ_waddr] <= occ_wdata;
    end
    rot_rd <= rotor_mem[cell_addr(pos_row, pos_col)];
    occ_rd <= occ_mem[cell_addr(pos_row, pos_col)];
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_cnt == '1) state_next = ST_IDLE;
      ST_IDLE:  if (item_acc && item.op == OP_DROP) state_next = ST_READ;
      ST_READ:  state_next = ST_EVAL;
      ST_EVAL:  state_next = walk_on ? ST_READ : ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_cnt      <= '0;
      result_valid <= 1'b0;
      pos_row      <= '0;
      pos_col      <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + cell_t'(1);
      end
      // walk position
      if (state == ST_IDLE && item_acc && item.op == OP_DROP) begin
        pos_row <= CENTER;
        pos_col <= CENTER;
      end else if (state == ST_EVAL && walk_on) begin
        pos_row <= row_step;
        pos_col <= col_step;
      end
      // result register
      if (state == ST_EVAL && !walk_on) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == ST_EVAL && !walk_on) begin
      result.rest_row   <= coord_to_byte(pos_row);
      result.rest_col   <= coord_to_byte(pos_col);
      result.hit_border <= occ_rd;
    end
  end

  // checks
  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> state == ST_IDLE)
    else $error("result pending outside idle");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !item_ready)
    else $error("ready during clearing pass");

  a_stop_gives_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL && !walk_on) |=> result_valid)
    else $error("walk stop without result");

  a_walk_in_grid: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |-> (pos_row <= COORD_MAX && pos_col <= COORD_MAX))
    else $error("walk left the grid");

  a_move_one_cell: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL && walk_on) |=>
      ($countones({pos_row != $past(pos_row), pos_col != $past(pos_col)}) == 1))
    else $error("walk step did not move exactly one axis");

endmodule

[tb/sv/rotor_router_aggregation_tb.sv]
// rotor_router_aggregation_tb: self-checking testbench for the rotor-router block
// drives write and drop transactions, predicts settle points, checks each result
// depends on rra_pkg and rotor_router_aggregation
`timescale 1ns / 100ps

module rotor_router_aggregation_tb;
  import rra_pkg::*;

  localparam int CELLS       = GRID_SIDE * GRID_SIDE;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int DRAIN_WAIT  = 32;
  localparam int NO_STEER    = -1;

  // grid model and queue of expected settle points
  class rra_scoreboard;
    logic [1:0]  rotor_mem [CELLS];
    bit          rotor_set [CELLS];
    bit          occupied [CELLS];
    rra_result_t settle_q[$];
    int          errors;

    function bit at_rim(int r, int c);
      return r == 0 || c == 0 || r >= GRID_SIDE - 1 || c >= GRID_SIDE - 1;
    endfunction

    // update the grid for an accepted transaction, queue a settle point for a drop
    function void note_item(rra_item_t it);
      int r, c, idx;
      logic [1:0] d;
      rra_result_t want;
      if (it.op == OP_WRITE) begin
        if (int'(it.cell_row) < GRID_SIDE && int'(it.cell_col) < GRID_SIDE) begin
          idx = int'(it.cell_row) * GRID_SIDE + int'(it.cell_col);
          rotor_mem[idx] = it.rotor_value;
          rotor_set[idx] = 1'b1;
        end
        return;
      end
      r = GRID_SIDE / 2;
      c = GRID_SIDE / 2;
      // walk while on an occupied interior cell
      while (1) begin
        idx = r * GRID_SIDE + c;
        if (!occupied[idx] || at_rim(r, c)) break;
        d = rotor_mem[idx];
        rotor_mem[idx] = d + 2'd1;
        case (dir_t'(d))
          DIR_RIGHT: c = c + 1;
          DIR_UP:    r = r - 1;
          DIR_LEFT:  c = c - 1;
          default:   r = r + 1;
        endcase
      end
      want.rest_row   = 8'(r);
      want.rest_col   = 8'(c);
      want.hit_border = occupied[idx];
      occupied[idx]   = 1'b1;
      settle_q.push_back(want);
    endfunction

    // compare a result transaction with the oldest expected one
    function void check_result(rra_result_t got);
      rra_result_t want;
      if (settle_q.size() == 0) begin
        $error("result with none expected: rest_row %0d rest_col %0d hit_border %0b",
               got.rest_row, got.rest_col, got.hit_border);
        errors++;
        return;
      end
      want = settle_q.pop_front();
      if (got.rest_row !== want.rest_row) begin
        $error("rest_row expected %0d actual %0d", want.rest_row, got.rest_row);
        errors++;
      end
      if (got.rest_col !== want.rest_col) begin
        $error("rest_col expected %0d actual %0d", want.rest_col, got.rest_col);
        errors++;
      end
      if (got.hit_border !== want.hit_border) begin
        $error("hit_border expected %0b actual %0b", want.hit_border, got.hit_border);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  rra_item_t   item_bus = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  rra_result_t result_bus;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycle_count = 0;

  rra_scoreboard sb = new();

  rotor_router_aggregation uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item_bus),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result_bus)
  );

  always #6 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.check_result(result_bus);
  end

  function automatic rra_item_t random_item();
    rra_item_t it;
    it.op          = op_t'($urandom_range(0, 1));
    it.cell_row    = 8'($urandom_range(0, 255));
    it.cell_col    = 8'($urandom_range(0, 255));
    it.rotor_value = 2'($urandom_range(0, 3));
    return it;
  endfunction

  // present one transaction, hold it until accepted, then note it
  task automatic send_item(input rra_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item_bus   <= it;
    do @(posedge clk); while (!item_ready);
    sb.note_item(it);
  endtask

  task automatic write_rotor(input int r, input int c, input logic [1:0] v);
    rra_item_t it;
    it             = random_item();
    it.op          = OP_WRITE;
    it.cell_row    = 8'(r);
    it.cell_col    = 8'(c);
    it.rotor_value = v;
    send_item(it);
  endtask

  // trace the coming walk; load any rotor it would read unwritten, or force
  // every rotor on the path to the steering direction, then drop the chip
  task automatic drop_chip(input int steer);
    logic [1:0] trial [int];
    int r, c, idx;
    logic [1:0] d;
    rra_item_t it;
    r = GRID_SIDE / 2;
    c = GRID_SIDE / 2;
    while (1) begin
      idx = r * GRID_SIDE + c;
      if (!sb.occupied[idx] || sb.at_rim(r, c)) break;
      if (trial.exists(idx)) begin
        d = trial[idx];
      end else begin
        if (steer != NO_STEER && int'(sb.rotor_mem[idx]) != steer)
          write_rotor(r, c, 2'(steer));
        else if (!sb.rotor_set[idx])
          write_rotor(r, c, 2'($urandom_range(0, 3)));
        d = sb.rotor_mem[idx];
      end
      trial[idx] = d + 2'd1;
      case (dir_t'(d))
        DIR_RIGHT: c = c + 1;
        DIR_UP:    r = r - 1;
        DIR_LEFT:  c = c - 1;
        default:   r = r + 1;
      endcase
    end
    it    = random_item();
    it.op = OP_DROP;
    send_item(it);
  endtask

  // mixed drops, scattered writes and rotor changes inside the cluster
  task automatic run_random(input int n);
    int roll;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < 45)
        drop_chip(NO_STEER);
      else if (roll < 80)
        write_rotor($urandom_range(0, 255), $urandom_range(0, 255), 2'($urandom_range(0, 3)));
      else
        write_rotor(GRID_SIDE / 2 - 20 + int'($urandom_range(0, 40)),
                    GRID_SIDE / 2 - 20 + int'($urandom_range(0, 40)),
                    2'($urandom_range(0, 3)));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // sender light, receiver heavy idling
    send_idle_pct = 18;
    recv_idle_pct = 72;

    // corner writes cover coordinate extremes and every rotor value
    write_rotor(0, 0, DIR_RIGHT);
    write_rotor(GRID_SIDE - 1, GRID_SIDE - 1, DIR_DOWN);
    write_rotor(0, GRID_SIDE - 1, DIR_UP);
    write_rotor(GRID_SIDE - 1, 0, DIR_LEFT);
    // first chip settles on the empty center
    drop_chip(NO_STEER);
    // one chip out of the center in each direction
    for (int d = 0; d < 4; d++) begin
      write_rotor(GRID_SIDE / 2, GRID_SIDE / 2, 2'(d));
      drop_chip(NO_STEER);
    end
    drop_chip(NO_STEER);
    drop_chip(NO_STEER);
    run_random(300);

    // sender heavy, receiver light idling
    send_idle_pct = 72;
    recv_idle_pct = 18;
    run_random(300);

    // no idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(300);

    item_valid <= 1'b0;
    while (sb.settle_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.settle_q.size() != 0) begin
      $error("%0d settle points never reported", sb.settle_q.size());
      sb.errors++;
    end

    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/rra_pkg.sv
rtl/rotor_router_aggregation.sv
tb/sv/rotor_router_aggregation_tb.sv
